// ----- rtl/slil_pkg.sv -----
// Shared constants for the shifted linear interpolation lookup.
package slil_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned FracBitsDef  = 16;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DivW   = 64;
  localparam int unsigned PosW   = 17;
  localparam int unsigned CountW = 9;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [PosW-1:0]  PosOne        = 17'h10000;
  localparam logic [DataW-1:0] InvVelReset   = 32'h0001_0000;
  localparam logic [CountW-1:0] CountReset   = 9'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_INV_VEL     = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_POINT_COUNT = 8'd1;

  localparam logic [1:0] REGION_BELOW  = 2'd0;
  localparam logic [1:0] REGION_INSIDE = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

endpackage

// ----- rtl/slil_ram.sv -----
// Generic single write, single read RAM with registered read data.
module slil_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/slil_div.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module slil_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [slil_pkg::DivW-1:0]   num_i,
  input  logic [slil_pkg::DataW-1:0]  den_i,
  output logic                        done_o,
  output logic [slil_pkg::DivW-1:0]   quot_o
);

  localparam int unsigned CntW = $clog2(slil_pkg::DivW + 1);

  logic [slil_pkg::DivW-1:0]  quot_q, quot_d;
  logic [slil_pkg::DataW-1:0] rem_q, rem_d;
  logic [slil_pkg::DataW-1:0] den_q, den_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [slil_pkg::DataW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[slil_pkg::DivW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(slil_pkg::DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the trial fits 33 bits
      if (trial >= {1'b0, den_q}) begin
        rem_d  = slil_pkg::DataW'(trial - {1'b0, den_q});
        quot_d = {quot_q[slil_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d  = trial[slil_pkg::DataW-1:0];
        quot_d = {quot_q[slil_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/shifted_linear_interp_lookup.sv -----
// Top level: time/value table with shifted-time binary search and interpolation.
//
// Input stream (s_axis_*): tuser selects a load (0) or a query (1). A load
// writes one table slot in the cycle it is accepted and gives no result.
// A query shifts its time by (1 - z) * inverse_velocity, searches the table
// and returns one result on the output stream (m_axis_*): value and slope in
// tdata, region in tuser.
// The configuration channel (cfg_*) is always ready and sets the inverse
// velocity (index 0) and the point count (index 1); write it while idle.
// One request is in work at a time. A query inside the table passes three
// setup states (S_MUL, S_SUM, S_END), then a binary search over the point
// count n clamped to 2..MAX_POINTS, each step in S_SRCH and S_CMP (the memory
// read is registered) plus a last check in S_SRCH, then S_DIFF and S_PROD for
// the difference and product, then the interpolation fraction and the slope
// through a one-bit-per-cycle 64-step divider. Queries outside the table go
// from S_END straight to S_DONE. The input is ready again in the cycle
// after the result is loaded. A finished result sits in the output register;
// when the receiver stalls, the next query is taken and worked on but waits
// at its end until the output register is free. Loads are taken when idle.
// Reset sets inverse_velocity 1.0 and point_count 2; the table is undefined.
module shifted_linear_interp_lookup #(
  parameter int unsigned MAX_POINTS = slil_pkg::MaxPointsDef,
  parameter int unsigned FRAC_BITS  = slil_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [7:0] entry_index, [39:8] entry_time, [71:40] entry_value,
  // [103:72] query_time, [120:104] query_position, [127:121] zero
  input  logic [127:0]  s_axis_tdata,
  // [0] req_type
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] profile_value, [63:32] profile_slope
  output logic [63:0]   m_axis_tdata,
  // [1:0] region
  output logic [1:0]    m_axis_tuser,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [slil_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MAX_POINTS);
  localparam int unsigned DW   = slil_pkg::DataW;
  localparam int unsigned PW   = slil_pkg::PosW;
  localparam int unsigned DlyW = PW + DW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_END  = 4'd3;
  localparam logic [3:0] S_SRCH = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_PROD = 4'd7;
  localparam logic [3:0] S_DIV1 = 4'd8;
  localparam logic [3:0] S_DIV2 = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_q, state_d;

  // configuration
  logic [DW-1:0]               inv_vel_q;
  logic [slil_pkg::CountW-1:0] point_count_q;

  // request fields
  logic          req_type;
  logic [7:0]    entry_index;
  logic [DW-1:0] entry_time, entry_value, query_time;
  logic [PW-1:0] query_position;

  assign entry_index    = s_axis_tdata[7:0];
  assign entry_time     = s_axis_tdata[39:8];
  assign entry_value    = s_axis_tdata[71:40];
  assign query_time     = s_axis_tdata[103:72];
  assign query_position = s_axis_tdata[120:104];
  assign req_type       = s_axis_tuser;

  logic s_fire;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // working registers
  logic [DW-1:0]   qt_q, tq_q;
  logic [PW-1:0]   fac_q;
  logic [DlyW-1:0] dly_q;
  logic [IdxW-1:0] nm1_q, lo_q, hi_q, mid_q;
  logic [DW-1:0]   tlo_q, thi_q, vlo_q, vhi_q;
  logic            neg_q;
  logic [DW-1:0]   mag_q, dt_q, el_q, qv_q;
  logic [slil_pkg::DivW-1:0] prod_q;

  // output register
  logic          out_valid_q;
  logic [DW-1:0] out_value_q, out_slope_q;
  logic [1:0]    out_region_q;
  logic          res_load;
  logic [DW-1:0] res_value, res_slope;
  logic [1:0]    res_region;

  // table memory: {time, value}
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  logic [2*DW-1:0]     ram_rdata;
  logic [DW-1:0]       rd_time, rd_value;

  assign rd_time  = ram_rdata[2*DW-1:DW];
  assign rd_value = ram_rdata[DW-1:0];
  assign ram_we   = s_fire && (req_type == slil_pkg::REQ_LOAD)
                    && (32'(entry_index) < MAX_POINTS);
  assign ram_waddr = IdxW'(32'(entry_index));

  slil_ram #(
    .Width (2 * DW),
    .Depth (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({entry_time, entry_value}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // divider
  logic                      div_start, div_done;
  logic [slil_pkg::DivW-1:0] div_num, div_quot;
  logic                      div_go;
  logic [slil_pkg::DivW-1:0] div_arg;

  slil_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_arg),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // point count clamp
  logic [IdxW-1:0] nm1_new;
  always_comb begin
    if (32'(point_count_q) < 32'd2) begin
      nm1_new = IdxW'(1);
    end else if (32'(point_count_q) > MAX_POINTS) begin
      nm1_new = IdxW'(MAX_POINTS - 1);
    end else begin
      nm1_new = IdxW'(32'(point_count_q) - 32'd1);
    end
  end

  logic [PW-1:0]   fac_new;
  logic [DW+1:0]   tsum;
  logic [IdxW:0]   mid_sum;
  logic [IdxW-1:0] mid_new, span;
  logic [DW:0]     dv;
  logic [slil_pkg::DivW-1:0] q2;
  logic            early_hit;

  assign fac_new = (query_position > slil_pkg::PosOne) ? '0
                   : PW'(slil_pkg::PosOne - query_position);
  assign tsum    = (DW+2)'(qt_q) + (DW+2)'(dly_q[DlyW-1:16]);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_new = mid_sum[IdxW:1];
  assign span    = hi_q - lo_q;
  assign dv      = {vhi_q[DW-1], vhi_q} - {vlo_q[DW-1], vlo_q};
  assign q2      = div_quot;
  // valid in S_END: at or below the first point, or at or above the last
  assign early_hit = (tq_q <= tlo_q) || (tq_q >= rd_time);

  always_comb begin
    state_d   = state_q;
    ram_raddr = '0;
    div_start = 1'b0;
    div_num   = prod_q;
    res_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire && (req_type == slil_pkg::REQ_QUERY)) state_d = S_MUL;
      end
      S_MUL: begin
        ram_raddr = '0;
        state_d   = S_SUM;
      end
      S_SUM: begin
        ram_raddr = nm1_q;
        state_d   = S_END;
      end
      S_END: begin
        ram_raddr = mid_new;
        if (early_hit) state_d = S_DONE;
        else state_d = S_SRCH;
      end
      S_SRCH: begin
        ram_raddr = mid_new;
        if (span > IdxW'(1)) state_d = S_CMP;
        else state_d = S_DIFF;
      end
      S_CMP: begin
        state_d = S_SRCH;
      end
      S_DIFF: begin
        state_d = S_PROD;
      end
      S_PROD: begin
        state_d = S_DIV1;
      end
      S_DIV1: begin
        // first pass: step of the value; second pass: slope
        if (div_done) begin
          div_start = 1'b1;
          div_num   = slil_pkg::DivW'(mag_q) << FRAC_BITS;
          state_d   = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_PROD) begin
      div_start = 1'b0;
    end
  end

  // divider start for the value pass; prod_q is ready in the cycle after S_PROD
  logic start_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      inv_vel_q     <= slil_pkg::InvVelReset;
      point_count_q <= slil_pkg::CountReset;
      out_valid_q   <= 1'b0;
      start_val_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_val_q <= (state_q == S_PROD);
      if (cfg_valid_i) begin
        if (cfg_index_i == slil_pkg::REG_INV_VEL) inv_vel_q <= cfg_data_i;
        else if (cfg_index_i == slil_pkg::REG_POINT_COUNT) begin
          point_count_q <= cfg_data_i[slil_pkg::CountW-1:0];
        end
      end
      if (res_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // value pass starts from start_val_q, slope pass from div_start
  assign div_go  = div_start || start_val_q;
  assign div_arg = start_val_q ? prod_q : div_num;

  // finish: value from first quotient, slope from second
  logic [DW-1:0] fin_value, fin_slope;
  always_comb begin
    fin_value = neg_q ? (vlo_q - qv_q) : (vlo_q + qv_q);
    if (neg_q) begin
      if (q2 > slil_pkg::DivW'(32'h8000_0000)) fin_slope = 32'h8000_0000;
      else fin_slope = DW'(0) - q2[DW-1:0];
    end else begin
      if (q2 > slil_pkg::DivW'(32'h7FFF_FFFF)) fin_slope = 32'h7FFF_FFFF;
      else fin_slope = q2[DW-1:0];
    end
  end

  logic          early_q;
  logic [DW-1:0] early_value_q;
  logic [1:0]    early_region_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      qt_q  <= query_time;
      fac_q <= fac_new;
      nm1_q <= nm1_new;
    end
    unique case (state_q)
      S_MUL: dly_q <= fac_q * inv_vel_q;
      S_SUM: begin
        tq_q  <= (tsum[DW+1:DW] != 2'b00) ? {DW{1'b1}} : tsum[DW-1:0];
        tlo_q <= rd_time;
        vlo_q <= rd_value;
        lo_q  <= '0;
        hi_q  <= nm1_q;
      end
      S_END: begin
        thi_q <= rd_time;
        vhi_q <= rd_value;
        if (tq_q <= tlo_q) begin
          early_q        <= 1'b1;
          early_value_q  <= vlo_q;
          early_region_q <= slil_pkg::REGION_BELOW;
        end else if (tq_q >= rd_time) begin
          early_q        <= 1'b1;
          early_value_q  <= rd_value;
          early_region_q <= slil_pkg::REGION_ABOVE;
        end else begin
          early_q <= 1'b0;
        end
      end
      S_SRCH: mid_q <= mid_new;
      S_CMP: begin
        if (rd_time <= tq_q) begin
          lo_q  <= mid_q;
          tlo_q <= rd_time;
          vlo_q <= rd_value;
        end else begin
          hi_q  <= mid_q;
          thi_q <= rd_time;
          vhi_q <= rd_value;
        end
      end
      S_DIFF: begin
        neg_q <= dv[DW];
        mag_q <= dv[DW] ? DW'(-dv) : dv[DW-1:0];
        dt_q  <= thi_q - tlo_q;
        el_q  <= tq_q - tlo_q;
      end
      S_PROD: prod_q <= slil_pkg::DivW'(mag_q) * slil_pkg::DivW'(el_q);
      S_DIV1: if (div_done) qv_q <= div_quot[DW-1:0];
      default: ;
    endcase
    if (res_load) begin
      out_value_q  <= res_value;
      out_slope_q  <= res_slope;
      out_region_q <= res_region;
    end
  end

  // result selection into the output register
  always_comb begin
    if (early_q) begin
      res_value  = early_value_q;
      res_slope  = '0;
      res_region = early_region_q;
    end else begin
      res_value  = fin_value;
      res_slope  = fin_slope;
      res_region = slil_pkg::REGION_INSIDE;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_slope_q, out_value_q};
  assign m_axis_tuser  = out_region_q;

endmodule

// ----- sim/tb_shifted_linear_interp_lookup.sv -----
// Testbench for the shifted linear interpolation lookup: table loads, queries, checks.
module tb_shifted_linear_interp_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] value;
    logic [31:0] slope;
    logic [1:0]  region;
  } profile_t;

  // Mirrors table and registers; queues the expected profile of each query.
  class profile_board;
    logic [31:0] times [256];
    logic [31:0] vals [256];
    logic [31:0] inv_vel;
    logic [8:0]  npts;
    profile_t    pending[$];
    int          errors;
    int          checked;

    function new();
      inv_vel = slil_pkg::InvVelReset;
      npts = slil_pkg::CountReset;
      errors = 0;
      checked = 0;
    endfunction

    function void note_request(logic kind, logic [7:0] idx, logic [31:0] et,
                               logic [31:0] ev, logic [31:0] qt, logic [16:0] qz);
      logic [63:0] z, dly, sh, mag, dt, el, q;
      logic [31:0] tq;
      int n, lo, hi, mid;
      longint vlo, vhi, dv, v;
      profile_t r;
      if (kind == slil_pkg::REQ_LOAD) begin
        times[idx] = et;
        vals[idx] = ev;
        return;
      end
      z = (qz > slil_pkg::PosOne) ? 64'(slil_pkg::PosOne) : 64'(qz);
      dly = ((64'h10000 - z) * 64'(inv_vel)) >> 16;
      sh = 64'(qt) + dly;
      tq = (sh > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sh[31:0];
      n = npts;
      if (n < 2) n = 2;
      if (n > 256) n = 256;
      if (tq <= times[0]) begin
        r = '{vals[0], 32'd0, slil_pkg::REGION_BELOW};
      end else if (tq >= times[n-1]) begin
        r = '{vals[n-1], 32'd0, slil_pkg::REGION_ABOVE};
      end else begin
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
          mid = lo + (hi - lo) / 2;
          if (times[mid] <= tq) lo = mid;
          else hi = mid;
        end
        vlo = longint'($signed(vals[lo]));
        vhi = longint'($signed(vals[hi]));
        dv = vhi - vlo;
        mag = (dv < 0) ? 64'(-dv) : 64'(dv);
        dt = 64'(times[hi]) - 64'(times[lo]);
        el = 64'(tq) - 64'(times[lo]);
        q = (mag * el) / dt;
        v = (dv < 0) ? vlo - longint'(q) : vlo + longint'(q);
        r.value = v[31:0];
        q = (mag << 16) / dt;
        if (dv < 0) begin
          if (q > 64'h8000_0000) q = 64'h8000_0000;
          v = -longint'(q);
        end else begin
          if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
          v = longint'(q);
        end
        r.slope = v[31:0];
        r.region = slil_pkg::REGION_INSIDE;
      end
      pending.push_back(r);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      errors++;
    endfunction

    function void check_result(logic [63:0] data, logic [1:0] reg_code);
      profile_t e;
      if (pending.size() == 0) begin
        report("unexpected result value", data[31:0], 32'd0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (data[31:0] !== e.value) report("value", data[31:0], e.value);
      if (data[63:32] !== e.slope) report("slope", data[63:32], e.slope);
      if (reg_code !== e.region) report("region", 32'(reg_code), 32'(e.region));
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [slil_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  profile_board board = new();
  int  cycles = 0;
  int  idle_pct = 24;
  int  queries = 0;
  int  loads = 0;
  logic [31:0] pts_t [256];

  shifted_linear_interp_lookup u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // valid stays up into a back-to-back request; drain() drops it
  task automatic send(logic kind, logic [7:0] idx, logic [31:0] et, logic [31:0] ev,
                      logic [31:0] qt, logic [16:0] qz);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, qz, qt, ev, et, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(kind, idx, et, ev, qt, qz);
    if (kind == slil_pkg::REQ_LOAD) loads++;
    else queries++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(negedge clk_i);
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [slil_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == slil_pkg::REG_INV_VEL) board.inv_vel = data;
    else board.npts = data[8:0];
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Ascending times with random gaps; occasionally repeated times.
  task automatic load_table(int n, int max_gap, bit fill_all);
    logic [31:0] t;
    int hi_idx;
    t = $urandom_range(1000);
    hi_idx = fill_all ? 255 : n - 1;
    for (int i = 0; i <= hi_idx; i++) begin
      pts_t[i] = t;
      send(slil_pkg::REQ_LOAD, i[7:0], t, $urandom, 32'd0, 17'd0);
      if ($urandom_range(15) != 0) t = t + $urandom_range(max_gap, 1);
    end
  endtask

  task automatic rand_query(int n);
    logic [31:0] qt;
    logic [16:0] qz;
    int i;
    i = $urandom_range(n - 1);
    case ($urandom_range(5))
      0: qt = $urandom;
      1: qt = pts_t[i];
      default: qt = pts_t[i] + $urandom_range(400);
    endcase
    case ($urandom_range(4))
      0: qz = slil_pkg::PosOne;
      1: qz = 17'($urandom_range(17'h1FFFF));
      default: qz = 17'($urandom_range(65536));
    endcase
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, qt, qz);
  endtask

  initial begin
    int n;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: two points with extreme values under reset registers, then extreme register settings.
    send(slil_pkg::REQ_LOAD, 8'd0, 32'd100, 32'h8000_0000, 32'd0, 17'd0);
    send(slil_pkg::REQ_LOAD, 8'd1, 32'd101, 32'h7FFF_FFFF, 32'd0, 17'd0);
    pts_t[0] = 100;
    pts_t[1] = 101;
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'd0, 17'd0);
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'd100, slil_pkg::PosOne);
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 17'h1FFFF);
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'd101, 17'h1FFFF);
    send(slil_pkg::REQ_LOAD, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         17'h1FFFF);
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'h8000_0000, slil_pkg::PosOne);
    send(slil_pkg::REQ_LOAD, 8'd1, 32'd110, 32'h8000_0000, 32'd0, 17'd0);
    send(slil_pkg::REQ_LOAD, 8'd0, 32'd100, 32'h7FFF_FFFF, 32'd0, 17'd0);
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'd105, slil_pkg::PosOne);
    write_reg(slil_pkg::REG_INV_VEL, 32'hFFFF_FFFF);
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'd0, 17'd0);
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'd50, 17'hFFFF);
    write_reg(slil_pkg::REG_INV_VEL, 32'd0);
    write_reg(slil_pkg::REG_POINT_COUNT, 32'd0);
    send(slil_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 32'd103, 17'd0);
    pts_t[0] = 100;
    pts_t[1] = 110;

    // Random phases over several table sizes and delay settings.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: n = 256;
        1: n = 511;
        2: n = 3;
        default: n = $urandom_range(40, 2);
      endcase
      idle_pct = (ph == 4) ? 0 : 24;
      write_reg(slil_pkg::REG_POINT_COUNT, n);
      write_reg(slil_pkg::REG_INV_VEL, (ph % 3 == 0) ? $urandom_range(5000) :
                                       (ph == 5) ? 32'hFFFF_FFFF : $urandom);
      if (n > 256) n = 256;
      // the full table from the first phase serves the oversized count
      if (ph != 1) load_table(n, (ph % 2) ? 300 : 32'h0100_0000 / n, ph < 2);
      for (int k = 0; k < 25; k++) begin
        rand_query(n);
        if (k == 20 && ph == 6) drain();
      end
    end

    drain();
    $display("Ran %0d loads and %0d queries, %0d results checked,", loads, queries,
             board.checked);
    $display("across table sizes 2 to 256 and delay settings from zero to full scale.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
